@@ hw/rtl/rrpf_pkg.sv @@
// Package for the rounded-rectangle pixel fill unit: widths, codes, geometry types
// and the helpers that build corner squares and boxes from the edge registers.
// No dependencies.
package rrpf_pkg;

   localparam int PIX_W       = 12;
   localparam int COLOR_W     = 8;
   localparam int RADIUS_W    = 8;
   localparam int MODE_W      = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 12;
   localparam int COORD_W     = 14;
   localparam int DELTA_W     = RADIUS_W + 1;
   localparam int SQ_W        = 2 * RADIUS_W;
   localparam int NUM_CORNERS = 4;
   localparam int NUM_BOXES   = 3;

   localparam int CLIP_X_MAX = 1024;
   localparam int CLIP_Y_MAX = 768;

   localparam logic [COLOR_W-1:0] TRANSPARENT_INDEX = 8'd15;

   typedef enum logic [MODE_W-1:0] {
      MODE_BOX       = 2'd0,
      MODE_DISC      = 2'd1,
      MODE_ROUND4    = 2'd2,
      MODE_ROUND_TOP = 2'd3
   } shape_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHAPE_MODE      = 3'd0,
      CSR_FILL_COLOR      = 3'd1,
      CSR_LEFT_EDGE       = 3'd2,
      CSR_TOP_EDGE        = 3'd3,
      CSR_RIGHT_EDGE      = 3'd4,
      CSR_BOTTOM_EDGE     = 3'd5,
      CSR_CORNER_RADIUS   = 3'd6,
      CSR_BACKGROUND_MODE = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      CLS_OUTSIDE = 2'd0,
      CLS_SQUARE  = 2'd1,
      CLS_DISC    = 2'd2
   } corner_class_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic      en;
      coord_type cx;
      coord_type cy;
      coord_type x0;
      coord_type x1;
      coord_type y0;
      coord_type y1;
   } corner_geom_type;

   typedef struct packed {
      logic      en;
      coord_type x0;
      coord_type x1;
      coord_type y0;
      coord_type y1;
   } box_geom_type;

   typedef struct packed {
      corner_geom_type [NUM_CORNERS-1:0] corner;
      box_geom_type [NUM_BOXES-1:0]      box;
      logic [SQ_W-1:0]                   rr;
      logic [COLOR_W-1:0]                fill_color;
      logic                              background_mode;
   } geom_type;

   // square around (cx,cy), clipped to the screen, both ends inclusive
   function automatic corner_geom_type make_corner(coord_type cx, coord_type cy,
                                                   coord_type r, coord_type clip_x,
                                                   coord_type clip_y);
      corner_geom_type g;
      g.en = 1'b1;
      g.cx = cx;
      g.cy = cy;
      g.x0 = cx - r;
      g.y0 = cy - r;
      g.x1 = cx + r;
      g.y1 = cy + r;
      if (g.x0 < 0) g.x0 = '0;
      if (g.y0 < 0) g.y0 = '0;
      if (g.x1 > clip_x) g.x1 = clip_x;
      if (g.y1 > clip_y) g.y1 = clip_y;
      return g;
   endfunction

   function automatic box_geom_type make_box(coord_type x0, coord_type x1,
                                             coord_type y0, coord_type y1);
      box_geom_type g;
      g.en = 1'b1;
      g.x0 = x0;
      g.x1 = x1;
      g.y0 = y0;
      g.y1 = y1;
      return g;
   endfunction

endpackage

@@ hw/rtl/rrpf_req_if.sv @@
// Pixel request channel: valid/ready handshake carrying one pixel coordinate.
// Depends on rrpf_pkg.
interface rrpf_req_if;
   logic                        valid;
   logic                        ready;
   logic [rrpf_pkg::PIX_W-1:0]  pixel_x;
   logic [rrpf_pkg::PIX_W-1:0]  pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

@@ hw/rtl/rrpf_rsp_if.sv @@
// Pixel result channel: valid/ready handshake carrying the write decision for one pixel.
// Depends on rrpf_pkg.
interface rrpf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          write_enable;
   logic [rrpf_pkg::COLOR_W-1:0]  pixel_color;
   logic [rrpf_pkg::PIX_W-1:0]    out_x;
   logic [rrpf_pkg::PIX_W-1:0]    out_y;

   modport source (output valid, output write_enable, output pixel_color, output out_x,
                   output out_y, input ready);
   modport sink   (input valid, input write_enable, input pixel_color, input out_x,
                   input out_y, output ready);
endinterface

@@ hw/rtl/rrpf_csr.sv @@
// Configuration registers and the registered shape geometry derived from them.
// Depends on rrpf_pkg.
module rrpf_csr #(
   parameter int CLIP_X_MAX = rrpf_pkg::CLIP_X_MAX,
   parameter int CLIP_Y_MAX = rrpf_pkg::CLIP_Y_MAX
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [rrpf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rrpf_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   output rrpf_pkg::geom_type                geom
);

   localparam rrpf_pkg::coord_type CLIP_X = rrpf_pkg::coord_type'(CLIP_X_MAX);
   localparam rrpf_pkg::coord_type CLIP_Y = rrpf_pkg::coord_type'(CLIP_Y_MAX);

   logic [rrpf_pkg::MODE_W-1:0]   shape_mode_ff;
   logic [rrpf_pkg::COLOR_W-1:0]  fill_color_ff;
   logic [rrpf_pkg::PIX_W-1:0]    left_edge_ff;
   logic [rrpf_pkg::PIX_W-1:0]    top_edge_ff;
   logic [rrpf_pkg::PIX_W-1:0]    right_edge_ff;
   logic [rrpf_pkg::PIX_W-1:0]    bottom_edge_ff;
   logic [rrpf_pkg::RADIUS_W-1:0] corner_radius_ff;
   logic                          background_mode_ff;

   rrpf_pkg::geom_type geom_in;
   rrpf_pkg::geom_type geom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_mode_ff      <= '0;
         fill_color_ff      <= '0;
         left_edge_ff       <= '0;
         top_edge_ff        <= '0;
         right_edge_ff      <= '0;
         bottom_edge_ff     <= '0;
         corner_radius_ff   <= '0;
         background_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (rrpf_pkg::csr_index_type'(csr_index))
            rrpf_pkg::CSR_SHAPE_MODE: begin
               shape_mode_ff <= csr_wr_data[rrpf_pkg::MODE_W-1:0];
            end
            rrpf_pkg::CSR_FILL_COLOR: begin
               fill_color_ff <= csr_wr_data[rrpf_pkg::COLOR_W-1:0];
            end
            rrpf_pkg::CSR_LEFT_EDGE: begin
               left_edge_ff <= csr_wr_data[rrpf_pkg::PIX_W-1:0];
            end
            rrpf_pkg::CSR_TOP_EDGE: begin
               top_edge_ff <= csr_wr_data[rrpf_pkg::PIX_W-1:0];
            end
            rrpf_pkg::CSR_RIGHT_EDGE: begin
               right_edge_ff <= csr_wr_data[rrpf_pkg::PIX_W-1:0];
            end
            rrpf_pkg::CSR_BOTTOM_EDGE: begin
               bottom_edge_ff <= csr_wr_data[rrpf_pkg::PIX_W-1:0];
            end
            rrpf_pkg::CSR_CORNER_RADIUS: begin
               corner_radius_ff <= csr_wr_data[rrpf_pkg::RADIUS_W-1:0];
            end
            rrpf_pkg::CSR_BACKGROUND_MODE: begin
               background_mode_ff <= csr_wr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rrpf_pkg::coord_type l;
      rrpf_pkg::coord_type t;
      rrpf_pkg::coord_type rt;
      rrpf_pkg::coord_type b;
      rrpf_pkg::coord_type r;
      rrpf_pkg::coord_type lr;
      rrpf_pkg::coord_type rr_x;
      rrpf_pkg::coord_type tr;
      rrpf_pkg::coord_type br;
      l    = rrpf_pkg::coord_type'({2'b00, left_edge_ff});
      t    = rrpf_pkg::coord_type'({2'b00, top_edge_ff});
      rt   = rrpf_pkg::coord_type'({2'b00, right_edge_ff});
      b    = rrpf_pkg::coord_type'({2'b00, bottom_edge_ff});
      r    = rrpf_pkg::coord_type'({6'b000000, corner_radius_ff});
      lr   = l + r;
      rr_x = rt - r;
      tr   = t + r;
      br   = b - r;

      geom_in                 = '0;
      geom_in.rr              = {8'b0, corner_radius_ff} * {8'b0, corner_radius_ff};
      geom_in.fill_color      = fill_color_ff;
      geom_in.background_mode = background_mode_ff;

      case (rrpf_pkg::shape_mode_type'(shape_mode_ff))
         rrpf_pkg::MODE_BOX: begin
            geom_in.box[0] = rrpf_pkg::make_box(l, rt, t, b);
         end
         rrpf_pkg::MODE_DISC: begin
            geom_in.corner[0] = rrpf_pkg::make_corner(l, t, r, CLIP_X, CLIP_Y);
         end
         rrpf_pkg::MODE_ROUND4: begin
            geom_in.corner[0] = rrpf_pkg::make_corner(lr, tr, r, CLIP_X, CLIP_Y);
            geom_in.corner[1] = rrpf_pkg::make_corner(rr_x, tr, r, CLIP_X, CLIP_Y);
            geom_in.corner[2] = rrpf_pkg::make_corner(lr, br, r, CLIP_X, CLIP_Y);
            geom_in.corner[3] = rrpf_pkg::make_corner(rr_x, br, r, CLIP_X, CLIP_Y);
            geom_in.box[0]    = rrpf_pkg::make_box(lr, rr_x, t, tr);
            geom_in.box[1]    = rrpf_pkg::make_box(l, rt, tr, br);
            geom_in.box[2]    = rrpf_pkg::make_box(lr, rr_x, br, b);
         end
         rrpf_pkg::MODE_ROUND_TOP: begin
            geom_in.corner[0] = rrpf_pkg::make_corner(lr, tr, r, CLIP_X, CLIP_Y);
            geom_in.corner[1] = rrpf_pkg::make_corner(rr_x, tr, r, CLIP_X, CLIP_Y);
            geom_in.box[0]    = rrpf_pkg::make_box(lr, rr_x, t, tr);
            geom_in.box[1]    = rrpf_pkg::make_box(l, rt, tr, b);
         end
         default: begin
         end
      endcase
   end

   // refreshed every cycle; box and corner tests read it at the input register, the color select at s3
   always_ff @(posedge clock) begin
      geom_ff <= geom_in;
   end

   assign geom = geom_ff;

endmodule

@@ hw/rtl/rrpf_corner.sv @@
// One corner disc test: square hit and deltas, then squares, then radius compare.
// Depends on rrpf_pkg.
module rrpf_corner (
   input  logic                              clock,
   input  logic                              adv,
   input  logic [rrpf_pkg::PIX_W-1:0]        pixel_x,
   input  logic [rrpf_pkg::PIX_W-1:0]        pixel_y,
   input  rrpf_pkg::corner_geom_type         geom,
   input  logic [rrpf_pkg::SQ_W-1:0]         rr,
   output rrpf_pkg::corner_class_type        cls
);

   localparam int DW = rrpf_pkg::DELTA_W;
   localparam int SW = rrpf_pkg::SQ_W;
   localparam int RW = rrpf_pkg::RADIUS_W;

   rrpf_pkg::coord_type xs;
   rrpf_pkg::coord_type ys;
   rrpf_pkg::coord_type dx;
   rrpf_pkg::coord_type dy;

   logic          insq_in;
   logic [DW-1:0] dx_in;
   logic [DW-1:0] dy_in;
   logic          insq_ff;
   logic [DW-1:0] dx_ff;
   logic [DW-1:0] dy_ff;

   logic [DW-1:0] dx_neg;
   logic [DW-1:0] dy_neg;
   logic [RW-1:0] adx;
   logic [RW-1:0] ady;
   logic [SW-1:0] sqx_in;
   logic [SW-1:0] sqy_in;
   logic          insq2_ff;
   logic [SW-1:0] sqx_ff;
   logic [SW-1:0] sqy_ff;
   logic [SW:0]   dsq_sum;

   assign xs = rrpf_pkg::coord_type'({2'b00, pixel_x});
   assign ys = rrpf_pkg::coord_type'({2'b00, pixel_y});
   assign dx = xs - geom.cx;
   assign dy = ys - geom.cy;

   assign insq_in = geom.en && (xs >= geom.x0) && (xs <= geom.x1)
                    && (ys >= geom.y0) && (ys <= geom.y1);
   // inside the square both deltas are within +-radius
   assign dx_in = dx[DW-1:0];
   assign dy_in = dy[DW-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         insq_ff <= insq_in;
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
      end
   end

   assign dx_neg = ~dx_ff + 1'b1;
   assign dy_neg = ~dy_ff + 1'b1;
   assign adx    = dx_ff[DW-1] ? dx_neg[RW-1:0] : dx_ff[RW-1:0];
   assign ady    = dy_ff[DW-1] ? dy_neg[RW-1:0] : dy_ff[RW-1:0];
   assign sqx_in = {{RW{1'b0}}, adx} * {{RW{1'b0}}, adx};
   assign sqy_in = {{RW{1'b0}}, ady} * {{RW{1'b0}}, ady};

   always_ff @(posedge clock) begin
      if (adv) begin
         insq2_ff <= insq_ff;
         sqx_ff   <= sqx_in;
         sqy_ff   <= sqy_in;
      end
   end

   assign dsq_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_comb begin
      if (!insq2_ff) begin
         cls = rrpf_pkg::CLS_OUTSIDE;
      end else if ({1'b0, rr} >= dsq_sum) begin
         cls = rrpf_pkg::CLS_DISC;
      end else begin
         cls = rrpf_pkg::CLS_SQUARE;
      end
   end

endmodule

@@ hw/rtl/rounded_rect_pixel_fill.sv @@
// Rounded-rectangle pixel fill: top level with input stage, box tests, corner
// units and the output register. Depends on rrpf_pkg, rrpf_req_if, rrpf_rsp_if,
// rrpf_csr and rrpf_corner.
//
//   channel   dir  handshake          payload
//   req_if    in   valid / ready      pixel_x, pixel_y
//   rsp_if    out  valid / ready      write_enable, pixel_color, out_x, out_y
//   csr_*     in   csr_wr_en          csr_index, csr_wr_data
//
// One pixel per clock sustained unless the output stalls; four register stages
// (input register, square/box test, squares, radius compare into the output
// register).
// Synchronous active-high reset clears the valid bits and the configuration registers.
// The whole pipeline advances when the output register is empty or taken; a stall
// freezes every stage, so nothing is dropped or repeated.
module rounded_rect_pixel_fill #(
   parameter int CLIP_X_MAX = rrpf_pkg::CLIP_X_MAX,
   parameter int CLIP_Y_MAX = rrpf_pkg::CLIP_Y_MAX
) (
   input  logic                              clock,
   input  logic                              reset,
   rrpf_req_if.sink                          req_if,
   rrpf_rsp_if.source                        rsp_if,
   input  logic                              csr_wr_en,
   input  logic [rrpf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rrpf_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   localparam int PW = rrpf_pkg::PIX_W;
   localparam int NC = rrpf_pkg::NUM_CORNERS;
   localparam int NB = rrpf_pkg::NUM_BOXES;

   rrpf_pkg::geom_type          geom;
   rrpf_pkg::corner_class_type  cls [NC];

   logic          adv;
   logic          s1_vld_ff;
   logic [PW-1:0] s1_x_ff;
   logic [PW-1:0] s1_y_ff;
   logic          s2_vld_ff;
   logic [PW-1:0] s2_x_ff;
   logic [PW-1:0] s2_y_ff;
   logic          s2_box_in;
   logic          s2_box_ff;
   logic          s3_vld_ff;
   logic [PW-1:0] s3_x_ff;
   logic [PW-1:0] s3_y_ff;
   logic          s3_box_ff;

   logic                          we_in;
   logic [rrpf_pkg::COLOR_W-1:0]  color_in;
   logic                          out_vld_ff;
   logic                          we_ff;
   logic [rrpf_pkg::COLOR_W-1:0]  color_ff;
   logic [PW-1:0]                 out_x_ff;
   logic [PW-1:0]                 out_y_ff;

   rrpf_csr #(
      .CLIP_X_MAX (CLIP_X_MAX),
      .CLIP_Y_MAX (CLIP_Y_MAX)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .geom        (geom)
   );

   assign adv          = !out_vld_ff || rsp_if.ready;
   assign req_if.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff  <= req_if.valid;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         out_vld_ff <= s3_vld_ff;
      end
   end

   always_comb begin
      rrpf_pkg::coord_type xs;
      rrpf_pkg::coord_type ys;
      xs        = rrpf_pkg::coord_type'({2'b00, s1_x_ff});
      ys        = rrpf_pkg::coord_type'({2'b00, s1_y_ff});
      s2_box_in = 1'b0;
      for (int i = 0; i < NB; i++) begin
         if (geom.box[i].en && (xs >= geom.box[i].x0) && (xs <= geom.box[i].x1)
             && (ys >= geom.box[i].y0) && (ys <= geom.box[i].y1)) begin
            s2_box_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff   <= req_if.pixel_x;
         s1_y_ff   <= req_if.pixel_y;
         s2_x_ff   <= s1_x_ff;
         s2_y_ff   <= s1_y_ff;
         s2_box_ff <= s2_box_in;
         s3_x_ff   <= s2_x_ff;
         s3_y_ff   <= s2_y_ff;
         s3_box_ff <= s2_box_ff;
         we_ff     <= we_in;
         color_ff  <= color_in;
         out_x_ff  <= s3_x_ff;
         out_y_ff  <= s3_y_ff;
      end
   end

   for (genvar g = 0; g < NC; g++) begin : g_corner
      rrpf_corner u_corner (
         .clock   (clock),
         .adv     (adv),
         .pixel_x (s1_x_ff),
         .pixel_y (s1_y_ff),
         .geom    (geom.corner[g]),
         .rr      (geom.rr),
         .cls     (cls[g])
      );
   end

   // box hits write first; in background mode the last corner square holding the pixel wins, else any disc writes
   always_comb begin
      rrpf_pkg::corner_class_type last;
      logic any_disc;
      last     = rrpf_pkg::CLS_OUTSIDE;
      any_disc = 1'b0;
      for (int i = 0; i < NC; i++) begin
         if (cls[i] != rrpf_pkg::CLS_OUTSIDE) last = cls[i];
         if (cls[i] == rrpf_pkg::CLS_DISC) any_disc = 1'b1;
      end
      we_in    = 1'b0;
      color_in = '0;
      if (s3_box_ff) begin
         we_in    = 1'b1;
         color_in = geom.fill_color;
      end else if (geom.background_mode) begin
         if (last == rrpf_pkg::CLS_DISC) begin
            we_in    = 1'b1;
            color_in = geom.fill_color;
         end else if (last == rrpf_pkg::CLS_SQUARE) begin
            we_in    = 1'b1;
            color_in = rrpf_pkg::TRANSPARENT_INDEX;
         end
      end else if (any_disc) begin
         we_in    = 1'b1;
         color_in = geom.fill_color;
      end
   end

   assign rsp_if.valid        = out_vld_ff;
   assign rsp_if.write_enable = we_ff;
   assign rsp_if.pixel_color  = color_ff;
   assign rsp_if.out_x        = out_x_ff;
   assign rsp_if.out_y        = out_y_ff;

endmodule
